### rtl/masked_address_acl_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the masked address access table
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MASKED_ADDRESS_ACL_TABLE_ASSERT_SVH
`define MASKED_ADDRESS_ACL_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// Condition that must hold at every edge outside reset.
`define MAACL_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("lbl failed");
// Antecedent implies consequent in the next cycle.
`define MAACL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("lbl failed");
`else
`define MAACL_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define MAACL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/maacl_pkg.sv
// ----------------------------------------------------------------------------
// maacl_pkg
// Types and constants shared by the masked address access table.
// ----------------------------------------------------------------------------
package maacl_pkg;

	localparam int DEF_ENTRIES      = 64;
	localparam int DEF_SERVICE_PORT = 123;
	localparam int DEF_LIMITED_BIT  = 4;
	localparam int DEF_IGNORE_BIT   = 1;

	localparam logic [2:0] OP_LOOKUP    = 3'd0;
	localparam logic [2:0] OP_ADD       = 3'd1;
	localparam logic [2:0] OP_CLEAR     = 3'd2;
	localparam logic [2:0] OP_REMOVE    = 3'd3;
	localparam logic [2:0] OP_REMOVE_IF = 3'd4;

	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_DEFAULT   = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_MULTICAST = 3'd4;

	localparam logic signed [15:0] DEFAULT_LIMIT = -16'sd1;

	// One stored rule.
	typedef struct packed {
		logic [31:0]        addr;
		logic [31:0]        mask;
		logic [2:0]         mb;
		logic [15:0]        rf;
		logic signed [15:0] lim;
		logic [31:0]        expiry;
	} entry_t;

endpackage

### rtl/masked_address_acl_table.sv
// ----------------------------------------------------------------------------
// masked_address_acl_table
// First-match IPv4 access table with sorted rules held in one memory.
// ----------------------------------------------------------------------------
// Each item takes one pass over the stored rules, which sit packed and sorted
// in descending order of address, mask and match bits in a single memory with
// a registered read. The pass reads one rule a cycle. A multicast source or an
// unknown op skips the pass; any other item visits at most the stored rules
// and then the default rule. A lookup stops at its match unless expired rules
// were dropped on the way, in which case it carries on to the end and packs
// the remaining rules down; an insert ripples the tail up one slot and a
// removal packs it down one slot, both in the same pass. The default rule is
// held in a register outside the memory and always sorts last, so the memory
// needs no clearing after reset. A new item is taken while the previous result
// still waits on the output side.
module masked_address_acl_table
	import maacl_pkg::*;
#(
	parameter int ENTRIES      = DEF_ENTRIES,
	parameter int SERVICE_PORT = DEF_SERVICE_PORT,
	parameter int LIMITED_BIT  = DEF_LIMITED_BIT,
	parameter int IGNORE_BIT   = DEF_IGNORE_BIT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// addr, mask, port, match_flags, rule_bits, peer_limit, expire_time,
	// now; zero fill above
	input  logic [183:0] s_tdata,
	// op
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// result_flags, result_peer_limit, status, monitor_on; zero fill above
	output logic [39:0]  m_tdata
);

`include "masked_address_acl_table_assert.svh"

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;

	logic [2:0]         op_q;
	logic [31:0]        addr_q, mask_q, exp_q, now_q;
	logic [15:0]        port_q, rf_q;
	logic signed [15:0] lim_q;
	logic [2:0]         mb_q;

	logic [IW-1:0] cnt_q, cnt_d, rd_q, rd_d, wr_q, wr_d, drop_q, drop_d;
	logic [CW-1:0] lref_q, lref_d;
	logic [15:0]   def_rf_q, def_rf_d;
	logic          found_q, found_d, ins_q, ins_d;
	entry_t        carry_q, carry_d;

	logic [IW-1:0] idx_s1;
	logic          vld_s1;

	logic [15:0]        res_rf_q, res_rf_d;
	logic signed [15:0] res_lim_q, res_lim_d;
	logic [2:0]         res_st_q, res_st_d;

	logic [15:0]        out_rf_q;
	logic signed [15:0] out_lim_q;
	logic [2:0]         out_st_q;
	logic               out_mon_q;

	logic          we, issue;
	logic [IW-1:0] waddr;
	entry_t        wdata, e, new_e;

	logic [31:0] key_a;
	logic        key_def, eq, gt, expired, hit, full, at_end;
	logic        accept, mcast, out_load;

	maacl_ram #(.ENTRIES(ENTRIES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (issue),
		.raddr (rd_q),
		.rdata (e)
	);

	assign key_a   = addr_q & mask_q;
	assign key_def = (key_a == 32'd0) && (mask_q == 32'd0) && (mb_q == 3'd0);
	assign eq      = {key_a, mask_q, mb_q} == {e.addr, e.mask, e.mb};
	assign gt      = {key_a, mask_q, mb_q} > {e.addr, e.mask, e.mb};
	assign expired = (e.expiry != 32'd0) && (e.expiry <= now_q);
	assign hit     = ((addr_q & e.mask) == e.addr)
		&& (!e.mb[0] || (port_q == 16'(SERVICE_PORT)));
	assign full    = cnt_q == IW'(ENTRIES - 1);
	assign at_end  = (state_q == S_WALK) && (rd_q == cnt_q) && !vld_s1;

	// An item is taken only from idle; a multicast lookup needs no walk.
	assign accept   = s_tvalid && s_tready;
	assign mcast    = (s_tuser == OP_LOOKUP) && (s_tdata[31:28] == 4'hE);
	// The finished result moves to the output once the output side is free.
	assign out_load = (state_q == S_DONE) && (!m_tvalid || m_tready);

	always_comb begin
		new_e.addr   = key_a;
		new_e.mask   = mask_q;
		new_e.mb     = mb_q;
		new_e.rf     = rf_q;
		new_e.lim    = lim_q;
		new_e.expiry = exp_q;
	end

	// Walk sequencer: one rule in from memory each cycle.
	always_comb begin
		logic stop;
		stop      = 1'b0;
		state_d   = state_q;
		cnt_d     = cnt_q;
		rd_d      = rd_q;
		wr_d      = wr_q;
		drop_d    = drop_q;
		lref_d    = lref_q;
		def_rf_d  = def_rf_q;
		found_d   = found_q;
		ins_d     = ins_q;
		carry_d   = carry_q;
		res_rf_d  = res_rf_q;
		res_lim_d = res_lim_q;
		res_st_d  = res_st_q;
		we        = 1'b0;
		waddr     = wr_q;
		wdata     = e;

		if (state_q == S_WALK && vld_s1) begin
			if (op_q == OP_LOOKUP) begin
				if (!found_q && expired) begin
					drop_d = drop_q + 1'b1;
					if (e.rf[LIMITED_BIT] && lref_q != '0) begin
						lref_d = lref_q - 1'b1;
					end
				end else begin
					we    = 1'b1;
					waddr = wr_q;
					wr_d  = wr_q + 1'b1;
					if (!found_q && hit) begin
						found_d   = 1'b1;
						res_rf_d  = e.rf;
						res_lim_d = e.lim;
						res_st_d  = ST_DONE;
						stop      = drop_q == '0;
					end
				end
			end else if (ins_q) begin
				we      = 1'b1;
				waddr   = idx_s1;
				wdata   = carry_q;
				carry_d = e;
			end else if (found_q) begin
				we    = 1'b1;
				waddr = wr_q;
				wr_d  = wr_q + 1'b1;
			end else if (eq) begin
				res_st_d = ST_DONE;
				waddr    = idx_s1;
				case (op_q)
					OP_ADD: begin
						we       = 1'b1;
						wdata.rf = e.rf | rf_q;
						if (rf_q[LIMITED_BIT] && !e.rf[LIMITED_BIT]) begin
							lref_d = lref_q + 1'b1;
						end
						stop = 1'b1;
					end
					OP_CLEAR: begin
						we       = 1'b1;
						wdata.rf = e.rf & ~rf_q;
						if (e.rf[LIMITED_BIT] && rf_q[LIMITED_BIT] && lref_q != '0) begin
							lref_d = lref_q - 1'b1;
						end
						stop = 1'b1;
					end
					default: begin
						if (op_q == OP_REMOVE && e.mb[2]) begin
							res_st_d = ST_NOT_FOUND;
							stop     = 1'b1;
						end else begin
							found_d = 1'b1;
							wr_d    = idx_s1;
							if (e.rf[LIMITED_BIT] && lref_q != '0) begin
								lref_d = lref_q - 1'b1;
							end
						end
					end
				endcase
			end else if (gt) begin
				if (op_q == OP_ADD && !full) begin
					we      = 1'b1;
					waddr   = idx_s1;
					wdata   = new_e;
					carry_d = e;
					ins_d   = 1'b1;
					if (rf_q[LIMITED_BIT]) begin
						lref_d = lref_q + 1'b1;
					end
				end else begin
					res_st_d = (op_q == OP_ADD) ? ST_FULL : ST_NOT_FOUND;
					stop     = 1'b1;
				end
			end
		end

		if (at_end) begin
			stop     = 1'b1;
			res_st_d = ST_DONE;
			if (op_q == OP_LOOKUP) begin
				cnt_d = cnt_q - drop_q;
				if (!found_q) begin
					res_rf_d  = def_rf_q;
					res_lim_d = DEFAULT_LIMIT;
					res_st_d  = ST_DEFAULT;
				end
			end else if (ins_q) begin
				we    = 1'b1;
				waddr = cnt_q;
				wdata = carry_q;
				cnt_d = cnt_q + 1'b1;
			end else if (found_q) begin
				cnt_d = cnt_q - 1'b1;
			end else if (op_q == OP_ADD) begin
				if (key_def) begin
					def_rf_d = def_rf_q | rf_q;
					if (rf_q[LIMITED_BIT] && !def_rf_q[LIMITED_BIT]) begin
						lref_d = lref_q + 1'b1;
					end
				end else if (full) begin
					res_st_d = ST_FULL;
				end else begin
					we    = 1'b1;
					waddr = cnt_q;
					wdata = new_e;
					cnt_d = cnt_q + 1'b1;
					if (rf_q[LIMITED_BIT]) begin
						lref_d = lref_q + 1'b1;
					end
				end
			end else if (op_q == OP_CLEAR && key_def) begin
				def_rf_d = def_rf_q & ~rf_q;
				if (def_rf_q[LIMITED_BIT] && rf_q[LIMITED_BIT] && lref_q != '0) begin
					lref_d = lref_q - 1'b1;
				end
			end else begin
				res_st_d = ST_NOT_FOUND;
			end
		end

		issue = (state_q == S_WALK) && !stop && (rd_q < cnt_q);
		if (issue) begin
			rd_d = rd_q + 1'b1;
		end
		if (stop) begin
			state_d = S_DONE;
		end

		// A new item restarts the walk bookkeeping and presets its result.
		if (accept) begin
			state_d   = (mcast || (s_tuser > OP_REMOVE_IF)) ? S_DONE : S_WALK;
			rd_d      = '0;
			wr_d      = '0;
			drop_d    = '0;
			found_d   = 1'b0;
			ins_d     = 1'b0;
			res_rf_d  = mcast ? (16'(1) << IGNORE_BIT) : 16'd0;
			res_lim_d = '0;
			res_st_d  = mcast ? ST_MULTICAST : ST_NOT_FOUND;
		end
		if (out_load) begin
			state_d = S_IDLE;
		end
	end

	assign s_tready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			lref_q    <= '0;
			def_rf_q  <= '0;
			vld_s1    <= 1'b0;
			m_tvalid  <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			lref_q   <= lref_d;
			def_rf_q <= def_rf_d;
			vld_s1   <= issue;
			m_tvalid <= out_load || (m_tvalid && !m_tready);
		end
	end

	// Item registers and walk bookkeeping.
	always_ff @(posedge clk) begin
		idx_s1    <= rd_q;
		rd_q      <= rd_d;
		wr_q      <= wr_d;
		drop_q    <= drop_d;
		found_q   <= found_d;
		ins_q     <= ins_d;
		carry_q   <= carry_d;
		res_rf_q  <= res_rf_d;
		res_lim_q <= res_lim_d;
		res_st_q  <= res_st_d;
		if (accept) begin
			op_q      <= s_tuser;
			addr_q    <= s_tdata[31:0];
			mask_q    <= s_tdata[63:32];
			port_q    <= s_tdata[79:64];
			mb_q      <= s_tdata[82:80];
			rf_q      <= s_tdata[98:83];
			lim_q     <= s_tdata[114:99];
			exp_q     <= s_tdata[146:115];
			now_q     <= s_tdata[178:147];
		end
		if (out_load) begin
			out_rf_q  <= res_rf_q;
			out_lim_q <= res_lim_q;
			out_st_q  <= res_st_q;
			out_mon_q <= lref_q != '0;
		end
	end

	assign m_tdata = {4'd0, out_mon_q, out_st_q, out_lim_q, out_rf_q};

	`MAACL_ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_q <= IW'(ENTRIES - 1))
	`MAACL_ASSERT_ALWAYS(a_lref_range, clk, arst_n, (state_q != S_IDLE) || (lref_q <= CW'(cnt_q) + 1'b1))
	`MAACL_ASSERT_ALWAYS(a_idle_no_read, clk, arst_n, !(s_tready && vld_s1))
	`MAACL_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, s_tvalid && s_tready, state_q != S_IDLE)

endmodule

### rtl/maacl_ram.sv
// ----------------------------------------------------------------------------
// maacl_ram
// Rule store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module maacl_ram
	import maacl_pkg::*;
#(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(ENTRIES)-1:0] waddr,
	input  entry_t                     wdata,
	input  logic                       re,
	input  logic [$clog2(ENTRIES)-1:0] raddr,
	output entry_t                     rdata
);

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
